// File: rtl/rdsq_pkg.sv
package rdsq_pkg;

    // Coordinate format: signed fixed point, FRAC_BITS fraction bits
    localparam int COORD_W    = 24;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_W     = COORD_W + 1;          // distance, FRAC_BITS fraction bits
    localparam int WHOLE_W    = DIST_W - FRAC_BITS;   // whole part of distance
    localparam int STEP_W     = 16;
    localparam int RAD_W      = 2 * DIST_W;           // sum of squares
    localparam int REM_W      = DIST_W + 3;           // square root partial remainder
    localparam int SQRT_CELLS = DIST_W;               // one root bit per cell
    localparam int DIV_CELLS  = WHOLE_W;              // one quotient bit per cell

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_fixed;
        logic [WHOLE_W-1:0] distance_whole;
        logic [WHOLE_W-1:0] step_index;
    } t_out_item;

    // Square root cell payload
    typedef struct packed {
        logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, MSB aligned
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
    } t_sqrt;

    // Divider cell payload
    typedef struct packed {
        logic [DIST_W-1:0]  dist_fx;
        logic [WHOLE_W-1:0] dq;   // dividend bits out at the top, quotient bits in at the bottom
        logic [STEP_W-1:0]  rem;
    } t_div;

endpackage

// File: rtl/radial_distance_step_quantizer.sv
// Throughput: one point per cycle while the skid slot is empty; a full skid slot halts the whole cell chain.
// Reset (i_rst_n low, synchronous): pipeline and output emptied, center set to 0,0,0,
// step size set to 1.
// Path: 3 front stages, 25 square root cells, 17 divider cells, output register.
module radial_distance_step_quantizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // point channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rdsq_pkg::t_in_item                i_in_data,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rdsq_pkg::t_out_item               o_out_data,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rdsq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rdsq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rdsq_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; step size 0 is
    // stored as 1 so the divider never sees a zero divisor. Unknown
    // indexes are dropped.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [STEP_W-1:0]         r_step_size;
    logic                      cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_center_z  <= '0;
            r_step_size <= STEP_W'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_CENTER_X:  r_center_x <= i_cfg_data[COORD_W-1:0];
                REG_CENTER_Y:  r_center_y <= i_cfg_data[COORD_W-1:0];
                REG_CENTER_Z:  r_center_z <= i_cfg_data[COORD_W-1:0];
                REG_STEP_SIZE: begin
                    r_step_size <= (i_cfg_data[STEP_W-1:0] == '0) ? STEP_W'(1)
                                                                : i_cfg_data[STEP_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The whole chain moves as one while the skid slot is
    // empty. A result that cannot leave parks in the skid slot, which
    // halts the chain on the next cycle; nothing is lost because the
    // skid slot catches the one transfer already under way.
    // ------------------------------------------------------------------
    logic      chain_en;
    logic      r_skid_vld;
    t_out_item r_skid;
    logic      r_out_vld;
    t_out_item r_out;

    assign chain_en   = ~r_skid_vld;
    assign o_in_ready = chain_en;

    // ------------------------------------------------------------------
    // Front end: |p - c| per axis, squares, sum of squares.
    // ------------------------------------------------------------------
    logic             front_vld;
    logic [RAD_W-1:0] front_rad;

    rdsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (chain_en),
        .i_vld   (i_in_valid & o_in_ready),
        .i_item  (i_in_data),
        .i_cx    (r_center_x),
        .i_cy    (r_center_y),
        .i_cz    (r_center_z),
        .o_vld   (front_vld),
        .o_rad   (front_rad)
    );

    // ------------------------------------------------------------------
    // Square root chain: each cell resolves one root bit, MSB first.
    // The floored root of the sum is the distance with FRAC_BITS
    // fraction bits.
    // ------------------------------------------------------------------
    logic  sq_vld  [SQRT_CELLS+1];
    t_sqrt sq_data [SQRT_CELLS+1];

    assign sq_vld[0]       = front_vld;
    assign sq_data[0].rad  = front_rad;
    assign sq_data[0].rem  = '0;
    assign sq_data[0].root = '0;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        rdsq_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_vld   (sq_vld[g]),
            .i_data  (sq_data[g]),
            .o_vld   (sq_vld[g+1]),
            .o_data  (sq_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Divider chain: whole distance / step size, one quotient bit per
    // cell. The distance rides along for the output.
    // ------------------------------------------------------------------
    logic dv_vld  [DIV_CELLS+1];
    t_div dv_data [DIV_CELLS+1];

    assign dv_vld[0]          = sq_vld[SQRT_CELLS];
    assign dv_data[0].dist_fx = sq_data[SQRT_CELLS].root;
    assign dv_data[0].dq      = sq_data[SQRT_CELLS].root[DIST_W-1:FRAC_BITS];
    assign dv_data[0].rem     = '0;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        rdsq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_vld   (dv_vld[g]),
            .i_data  (dv_data[g]),
            .i_step  (r_step_size),
            .o_vld   (dv_vld[g+1]),
            .o_data  (dv_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register with skid slot.
    // ------------------------------------------------------------------
    t_out_item chain_res;
    logic      chain_push;
    logic      out_take;

    always_comb begin
        chain_res.distance_fixed = dv_data[DIV_CELLS].dist_fx;
        chain_res.distance_whole = dv_data[DIV_CELLS].dist_fx[DIST_W-1:FRAC_BITS];
        chain_res.step_index     = dv_data[DIV_CELLS].dq;
    end

    assign chain_push = chain_en & dv_vld[DIV_CELLS];
    assign out_take   = r_out_vld & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_take) begin
            // output slot free this cycle: skid first, else the chain
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= chain_push;
            end
        end else if (chain_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_take) begin
            r_out <= r_skid_vld ? r_skid : chain_res;
        end
        if (r_out_vld && !out_take && chain_push) begin
            r_skid <= chain_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/rdsq_front.sv
module rdsq_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  rdsq_pkg::t_in_item                  i_item,
    input  logic signed [rdsq_pkg::COORD_W-1:0] i_cx,
    input  logic signed [rdsq_pkg::COORD_W-1:0] i_cy,
    input  logic signed [rdsq_pkg::COORD_W-1:0] i_cz,
    output logic                                o_vld,
    output logic [rdsq_pkg::RAD_W-1:0]          o_rad
);
    import rdsq_pkg::*;

    logic signed [DIST_W-1:0] dx, dy, dz;
    logic [DIST_W-1:0]        n_mx, n_my, n_mz;
    logic [DIST_W-1:0]        r_mx, r_my, r_mz;
    logic [RAD_W-1:0]         n_sx, n_sy, n_sz;
    logic [RAD_W-1:0]         r_sx, r_sy, r_sz;
    logic [RAD_W-1:0]         n_sum;
    logic [RAD_W-1:0]         r_sum;
    logic                     r_vld1, r_vld2, r_vld3;

    // stage 1: absolute differences
    always_comb begin
        dx   = DIST_W'(i_item.point_x) - DIST_W'(i_cx);
        dy   = DIST_W'(i_item.point_y) - DIST_W'(i_cy);
        dz   = DIST_W'(i_item.point_z) - DIST_W'(i_cz);
        n_mx = dx[DIST_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
        n_my = dy[DIST_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
        n_mz = dz[DIST_W-1] ? DIST_W'(-dz) : DIST_W'(dz);
    end

    // stage 2: squares, full product width (operands carry only DIST_W bits)
    always_comb begin
        n_sx = RAD_W'(r_mx) * RAD_W'(r_mx);
        n_sy = RAD_W'(r_my) * RAD_W'(r_my);
        n_sz = RAD_W'(r_mz) * RAD_W'(r_mz);
    end

    // stage 3: sum, cannot overflow (below 3 * 2^48)
    assign n_sum = r_sx + r_sy + r_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx  <= n_mx;
            r_my  <= n_my;
            r_mz  <= n_mz;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sz  <= n_sz;
            r_sum <= n_sum;
        end
    end

    assign o_vld = r_vld3;
    assign o_rad = r_sum;

endmodule

// File: rtl/rdsq_sqrt_cell.sv
module rdsq_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  rdsq_pkg::t_sqrt i_data,
    output logic            o_vld,
    output rdsq_pkg::t_sqrt o_data
);
    import rdsq_pkg::*;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    t_sqrt            n_data;
    t_sqrt            r_data;
    logic             r_vld;

    // one restoring step: bring down two radicand bits, try root bit = 1
    always_comb begin
        rem_sh      = {i_data.rem[REM_W-3:0], i_data.rad[RAD_W-1 -: 2]};
        trial       = REM_W'({i_data.root, 2'b01});
        ge          = (rem_sh >= trial);
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        n_data.rem  = ge ? (rem_sh - trial) : rem_sh;
        n_data.root = {i_data.root[DIST_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// File: rtl/rdsq_div_cell.sv
module rdsq_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  rdsq_pkg::t_div               i_data,
    input  logic [rdsq_pkg::STEP_W-1:0]  i_step,
    output logic                         o_vld,
    output rdsq_pkg::t_div               o_data
);
    import rdsq_pkg::*;

    logic [STEP_W:0] rem_sh;
    logic [STEP_W:0] diff;
    logic            ge;
    t_div            n_data;
    t_div            r_data;
    logic            r_vld;

    // one restoring division step
    always_comb begin
        rem_sh         = {i_data.rem, i_data.dq[WHOLE_W-1]};
        diff           = rem_sh - {1'b0, i_step};
        ge             = (rem_sh >= {1'b0, i_step});
        n_data.dist_fx = i_data.dist_fx;
        n_data.dq      = {i_data.dq[WHOLE_W-2:0], ge};
        n_data.rem     = ge ? diff[STEP_W-1:0] : rem_sh[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// File: sim/rdsq_checker.sv
`timescale 1ns / 1ps

// Watches the point, result and config channels. Keeps its own copy of the
// center and step registers and predicts each result. Results are checked in order.
module rdsq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  rdsq_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  rdsq_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [rdsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rdsq_pkg::*;

    logic signed [COORD_W-1:0] center_x = '0;
    logic signed [COORD_W-1:0] center_y = '0;
    logic signed [COORD_W-1:0] center_z = '0;
    logic [STEP_W-1:0]         step_div = STEP_W'(1);

    t_out_item distance_q[$];
    int        fail_count   = 0;
    int        result_count = 0;
    int        pending_cnt  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    task automatic record_failure(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Exact squared distance, a floored bitwise square root, then the whole part divided by the step.
    function automatic t_out_item quantize_point(input t_in_item p);
        longint            dx;
        longint            dy;
        longint            dz;
        longint unsigned   sumsq;
        longint unsigned   root;
        longint unsigned   trial;
        longint unsigned   whole;
        int                b;
        t_out_item         r;
        dx = longint'($signed(p.point_x)) - longint'(center_x);
        dy = longint'($signed(p.point_y)) - longint'(center_y);
        dz = longint'($signed(p.point_z)) - longint'(center_z);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        sumsq = dx * dx + dy * dy + dz * dz;
        root = 0;
        for (b = DIST_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sumsq) root = trial;
        end
        whole = root >> FRAC_BITS;
        r.distance_fixed = DIST_W'(root);
        r.distance_whole = WHOLE_W'(whole);
        r.step_index     = WHOLE_W'(whole / longint'(step_div));
        return r;
    endfunction

    task automatic compare_field(input string name, input longint unsigned got,
                                 input longint unsigned want);
        if (got != want)
            record_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                     result_count, name, got, want));
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (distance_q.size() == 0) begin
            record_failure($sformatf("result %0d arrived with no point outstanding",
                                     result_count));
        end else begin
            want = distance_q.pop_front();
            compare_field("distance_fixed", got.distance_fixed, want.distance_fixed);
            compare_field("distance_whole", got.distance_whole, want.distance_whole);
            compare_field("step_index", got.step_index, want.step_index);
        end
        result_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            center_x = '0;
            center_y = '0;
            center_z = '0;
            step_div = STEP_W'(1);
            distance_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_X:  center_x = i_cfg_data[COORD_W-1:0];
                    REG_CENTER_Y:  center_y = i_cfg_data[COORD_W-1:0];
                    REG_CENTER_Z:  center_z = i_cfg_data[COORD_W-1:0];
                    REG_STEP_SIZE: begin
                        // zero divisor is stored as one
                        step_div = i_cfg_data[STEP_W-1:0];
                        if (step_div == '0) step_div = STEP_W'(1);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) distance_q.push_back(quantize_point(i_in_data));
        end
        pending_cnt <= distance_q.size();
    end

endmodule

// File: sim/tb_radial_distance_step_quantizer.sv
`timescale 1ns / 1ps

module tb_radial_distance_step_quantizer;
    import rdsq_pkg::*;

    // Coordinate extremes and handy fixed-point values
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] UNIT      = COORD_W'(1 << FRAC_BITS);
    localparam int NUM_REGS        = REG_STEP_SIZE + 1;   // first unused index
    localparam int RAND_PHASES     = 14;
    localparam int POINTS_PER_PH   = 120;
    localparam int HOLD_PHASE      = 4;
    localparam int LONG_HOLD       = 400;    // receiver hold-off, cycles
    localparam int DRAIN_CYCLES    = 60;     // pipeline latency plus margin
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no transfer on any channel

    // How a random point is placed relative to the current center
    typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_MID, SPREAD_EDGE} t_spread;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Shared with the result sink: steady mode and a one-shot long hold-off
    bit out_steady   = 1'b0;
    bit hold_request = 1'b0;

    // Center currently programmed, so near-center points can be aimed
    logic [COORD_W-1:0] cur_x = '0;
    logic [COORD_W-1:0] cur_y = '0;
    logic [COORD_W-1:0] cur_z = '0;

    radial_distance_step_quantizer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rdsq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake on every channel ends the run
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Mostly zero, some short, a few long; steady mode gives none at all
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady)      return 0;
        else if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)      return COORD_MIN;
        else if (r < 30) return COORD_MAX;
        else if (r < 50) return '0;
        else             return COORD_W'($urandom());
    endfunction

    // Step register data; in most choices the upper bits past the step field carry junk
    function automatic logic [CFG_DATA_W-1:0] pick_step_data();
        int r;
        logic [CFG_DATA_W-1:0] junk;
        r = $urandom_range(0, 99);
        junk = CFG_DATA_W'($urandom()) << STEP_W;
        if (r < 15)      return CFG_DATA_W'(1);
        else if (r < 25) return junk | CFG_DATA_W'({STEP_W{1'b1}});
        else if (r < 35) return junk;                 // zero step, stored as one
        else if (r < 75) return junk | CFG_DATA_W'($urandom_range(1, 300));
        else             return CFG_DATA_W'($urandom());
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] ctr,
                                                      input t_spread spread);
        case (spread)
            SPREAD_FULL: return COORD_W'($urandom());
            SPREAD_NEAR: return ctr + COORD_W'($urandom_range(0, 8192)) - COORD_W'(4096);
            SPREAD_MID:  return ctr + COORD_W'($urandom_range(0, 1 << 17)) - COORD_W'(1 << 16);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    default: return ctr;
                endcase
            end
        endcase
    endfunction

    // Optional idle gap, then offer the point and hold it until the transfer
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input int gap);
        t_in_item p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Sender stops; returns once every predicted result has come back.
    // pending is registered, so look only after the next edge.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // cfg_valid stays up across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Every point makes a result, so a drained checker means an idle block
    task automatic apply_setting(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                 input logic [COORD_W-1:0] cz,
                                 input logic [CFG_DATA_W-1:0] step_data, input bit stray);
        pause_until_drained();
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
                      CFG_DATA_W'($urandom()));
        write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(REG_CENTER_Z, CFG_DATA_W'(cz));
        write_reg(REG_STEP_SIZE, step_data);
        cfg_valid <= 1'b0;
        cur_x = cx;
        cur_y = cy;
        cur_z = cz;
    endtask

    // Result sink: random stalls, steady stretches, and one long hold-off
    // that lets the pipeline fill and back-pressure the point channel
    initial begin : result_sink
        int n;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                n = pick_gap(out_steady);
                if (n > 0) begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int      ph;
        int      n;
        int      r;
        bit      in_steady;
        t_spread spread;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero center, unit step. Zero distance, one LSB,
        // a negative LSB, single-axis extremes, all-max, all-min, exact 5.0
        // and sqrt(3).
        send_point('0, '0, '0, 0);
        send_point(COORD_W'(1), '0, '0, 0);
        send_point('0, '0, {COORD_W{1'b1}}, 0);
        send_point(COORD_MAX, '0, '0, 1);
        send_point('0, COORD_MIN, '0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 2);
        send_point(COORD_W'(3) * UNIT, COORD_W'(4) * UNIT, '0, 0);
        send_point(UNIT, -UNIT, UNIT, 0);

        // Center at the top corner: largest possible distance and zero.
        // A zero step write must be stored as one; the stray write is dropped.
        apply_setting(COORD_MAX, COORD_MAX, COORD_MAX, '0, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_point(COORD_MIN, COORD_MAX, '0, 0);

        // Largest step, data written with every bit set
        apply_setting(COORD_MIN, '0, COORD_W'(1), {CFG_DATA_W{1'b1}}, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_point(COORD_MIN, '0, COORD_W'(1), 0);
        send_point(COORD_MAX, '0, COORD_W'(1), 0);

        // Step of 7 with junk above the step field; distances around
        // multiples of 7 exercise the quotient edges
        apply_setting(COORD_W'(8'h80), -COORD_W'(8'h80), '0,
                      (CFG_DATA_W'(8'hAB) << STEP_W) | CFG_DATA_W'(7), 1'b1);
        send_point(COORD_W'(8'h80) + COORD_W'(7) * UNIT, -COORD_W'(8'h80), '0, 0);
        send_point(COORD_W'(8'h80) + COORD_W'(7) * UNIT - COORD_W'(1), -COORD_W'(8'h80),
                   '0, 0);
        send_point(COORD_W'(8'h80) + COORD_W'(14) * UNIT, -COORD_W'(8'h80), '0, 0);
        send_point(COORD_W'(8'h80) - COORD_W'(21) * UNIT, -COORD_W'(8'h80), '0, 0);

        // Random phases, each with its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            apply_setting(pick_center(), pick_center(), pick_center(), pick_step_data(),
                          $urandom_range(0, 1));
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE) begin
                // keep offering while the sink holds off; start once it has
                in_steady    = 1'b1;
                hold_request = 1'b1;
                wait (!hold_request);
            end
            for (n = 0; n < POINTS_PER_PH; n++) begin
                if ($urandom_range(0, 199) == 0) pause_until_drained();
                r = $urandom_range(0, 99);
                if (r < 40)      spread = SPREAD_FULL;
                else if (r < 70) spread = SPREAD_NEAR;
                else if (r < 85) spread = SPREAD_MID;
                else             spread = SPREAD_EDGE;
                send_point(pick_coord(cur_x, spread), pick_coord(cur_y, spread),
                           pick_coord(cur_z, spread), pick_gap(in_steady));
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
